// ===== sv/lct_pkg.sv =====
// Shared types, constants and helpers of the lane centroid tracker.
package lct_pkg;

  // Coordinate format and steering constants.
  localparam int COORD_FRAC_BITS = 4;
  localparam int BASE_SPEED      = 30;
  localparam int GAIN_FRAC       = 8;

  // Field widths.
  localparam int X_W    = 16;
  localparam int Y_W    = 14;
  localparam int GAIN_W = 10;
  localparam int ERR_W  = 13;
  localparam int SPD_W  = 16;
  localparam int DX2_W  = 2 * X_W;
  localparam int DY2_W  = 2 * Y_W;
  localparam int DIST_W = 34;
  localparam int NUM_W  = X_W + 2;
  localparam int G_W    = GAIN_W + 1 + ERR_W;

  // Lanes.
  localparam int NUM_LANES  = 2;
  localparam int LANE_RIGHT = 0;
  localparam int LANE_LEFT  = 1;

  // Queue between front and back, and result queue.
  localparam int MQ_DEPTH = 4;
  localparam int MQ_AW    = $clog2(MQ_DEPTH);
  localparam int MQ_CW    = $clog2(MQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);
  localparam int USED_W   = $clog2(OQ_DEPTH + 4);

  // Configuration port.
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef enum logic [2:0] {
    REG_CENTER_X         = 3'd0,
    REG_CENTER_Y         = 3'd1,
    REG_RIGHT_SEED_MIN_X = 3'd2,
    REG_LEFT_SEED_MAX_X  = 3'd3,
    REG_SEED_MIN_Y       = 3'd4,
    REG_WINDOW_X         = 3'd5,
    REG_WINDOW_Y         = 3'd6,
    REG_GAIN_Q8          = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [X_W-1:0]    center_x;
    logic [Y_W-1:0]    center_y;
    logic [X_W-1:0]    right_seed_min_x;
    logic [X_W-1:0]    left_seed_max_x;
    logic [Y_W-1:0]    seed_min_y;
    logic [X_W-1:0]    window_x;
    logic [Y_W-1:0]    window_y;
    logic [GAIN_W-1:0] gain_q8;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    center_x:         16'd5120,
    center_y:         14'd720,
    right_seed_min_x: 16'd7040,
    left_seed_max_x:  16'd3200,
    seed_min_y:       14'd320,
    window_x:         16'd1120,
    window_y:         14'd960,
    gain_q8:          10'd77
  };

  // Input beat: mode 0 is a centroid, mode 1 closes the frame.
  typedef struct packed {
    logic           mode;
    logic [X_W-1:0] blob_x;
    logic [Y_W-1:0] blob_y;
  } in_item_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] steer_error;
    logic signed [SPD_W-1:0] first_speed;
    logic signed [SPD_W-1:0] second_speed;
  } out_item_t;

  // Classified item held between front and back.
  typedef struct packed {
    logic                 eof;
    logic [X_W-1:0]       x;
    logic [Y_W-1:0]       y;
    logic [NUM_LANES-1:0] zone;
  } mq_item_t;

  // End-of-frame request from the tracker to the steering stages.
  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] num;
  } eof_req_t;

  // Occupancy of the steering stages and result queue.
  typedef struct packed {
    logic [USED_W-1:0] used;
  } steer_stat_t;

  function automatic logic [X_W-1:0] absdiff(input logic [X_W-1:0] a,
                                             input logic [X_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== sv/lct_cfg.sv =====
// Configuration register file with its APB-style access port.
module lct_cfg import lct_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  cfg_reg_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = cfg_reg_t'(paddr[CFG_AW-1:2]);
  assign cfg    = cfg_r;

  // Write decode: each register keeps only its own width.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_CENTER_X:         cfg_nxt.center_x         = pwdata[X_W-1:0];
        REG_CENTER_Y:         cfg_nxt.center_y         = pwdata[Y_W-1:0];
        REG_RIGHT_SEED_MIN_X: cfg_nxt.right_seed_min_x = pwdata[X_W-1:0];
        REG_LEFT_SEED_MAX_X:  cfg_nxt.left_seed_max_x  = pwdata[X_W-1:0];
        REG_SEED_MIN_Y:       cfg_nxt.seed_min_y       = pwdata[Y_W-1:0];
        REG_WINDOW_X:         cfg_nxt.window_x         = pwdata[X_W-1:0];
        REG_WINDOW_Y:         cfg_nxt.window_y         = pwdata[Y_W-1:0];
        REG_GAIN_Q8:          cfg_nxt.gain_q8          = pwdata[GAIN_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      REG_CENTER_X:         prdata = CFG_DW'(cfg_r.center_x);
      REG_CENTER_Y:         prdata = CFG_DW'(cfg_r.center_y);
      REG_RIGHT_SEED_MIN_X: prdata = CFG_DW'(cfg_r.right_seed_min_x);
      REG_LEFT_SEED_MAX_X:  prdata = CFG_DW'(cfg_r.left_seed_max_x);
      REG_SEED_MIN_Y:       prdata = CFG_DW'(cfg_r.seed_min_y);
      REG_WINDOW_X:         prdata = CFG_DW'(cfg_r.window_x);
      REG_WINDOW_Y:         prdata = CFG_DW'(cfg_r.window_y);
      REG_GAIN_Q8:          prdata = CFG_DW'(cfg_r.gain_q8);
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== sv/lct_front.sv =====
// Front end: accepts input beats, tests the seed zones and queues the items.
module lct_front import lct_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  in_item_t in_data,
  input  logic     push,
  output logic     full,
  output mq_item_t mq_head,
  output logic     mq_valid,
  input  logic     mq_pop
);

  mq_item_t         mq_mem_r [MQ_DEPTH];
  logic [MQ_AW-1:0] wr_ptr_r;
  logic [MQ_AW-1:0] rd_ptr_r;
  logic [MQ_CW-1:0] cnt_r;
  logic             push_ok;
  logic             pop_ok;
  mq_item_t         item;
  logic             y_ok;

  assign full     = (cnt_r == MQ_CW'(MQ_DEPTH));
  assign mq_valid = (cnt_r != '0);
  assign mq_head  = mq_mem_r[rd_ptr_r];
  assign push_ok  = push && !full;
  assign pop_ok   = mq_pop && mq_valid;

  // Classify the beat: end of frame or centroid, and which seed zones hold it.
  always_comb begin
    y_ok = in_data.blob_y > cfg.seed_min_y;
    item.eof = in_data.mode;
    item.x   = in_data.blob_x;
    item.y   = in_data.blob_y;
    item.zone[LANE_RIGHT] = !in_data.mode && y_ok &&
                            (in_data.blob_x > cfg.right_seed_min_x);
    item.zone[LANE_LEFT]  = !in_data.mode && y_ok &&
                            (in_data.blob_x < cfg.left_seed_max_x);
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mq_mem_r[wr_ptr_r] <= item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == MQ_AW'(MQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == MQ_AW'(MQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/lct_track.sv =====
// Back end: lane seeding, windowed nearest-centroid tracking and frame close.
module lct_track import lct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  mq_item_t    mq_head,
  input  logic        mq_valid,
  output logic        mq_pop,
  input  steer_stat_t stat,
  output eof_req_t    eof_req
);

  // Lane state.
  logic [X_W-1:0]       ref_x_r  [NUM_LANES];
  logic [Y_W-1:0]       ref_y_r  [NUM_LANES];
  logic [X_W-1:0]       cur_x_r  [NUM_LANES];
  logic [Y_W-1:0]       cur_y_r  [NUM_LANES];
  logic [DIST_W-1:0]    best_r   [NUM_LANES];
  logic [NUM_LANES-1:0] seeded_r;
  logic                 fresh_r;

  // Issue stage signals.
  logic                 a_go;
  logic                 eof_busy;
  logic [NUM_LANES-1:0] a_seed;
  logic [NUM_LANES-1:0] a_win;
  logic [X_W-1:0]       a_rx [NUM_LANES];
  logic [Y_W-1:0]       a_ry [NUM_LANES];
  logic [X_W-1:0]       a_dx [NUM_LANES];
  logic [Y_W-1:0]       a_dy [NUM_LANES];

  // Square stage registers.
  logic                 b_valid_r;
  logic                 b_eof_r;
  logic [X_W-1:0]       b_x_r;
  logic [Y_W-1:0]       b_y_r;
  logic [X_W-1:0]       b_dx_r [NUM_LANES];
  logic [Y_W-1:0]       b_dy_r [NUM_LANES];
  logic [NUM_LANES-1:0] b_win_r;

  // Compare stage registers.
  logic                 c_valid_r;
  logic                 c_eof_r;
  logic [X_W-1:0]       c_x_r;
  logic [Y_W-1:0]       c_y_r;
  logic [DX2_W-1:0]     c_sqx_r [NUM_LANES];
  logic [DY2_W-1:0]     c_sqy_r [NUM_LANES];
  logic [NUM_LANES-1:0] c_win_r;

  logic [DIST_W-1:0]    c_dist     [NUM_LANES];
  logic [DIST_W-1:0]    c_best_eff [NUM_LANES];
  logic [DIST_W-1:0]    best_nxt   [NUM_LANES];
  logic [NUM_LANES-1:0] c_take;

  // An end of frame rewrites the references, so nothing issues behind it until
  // it has closed the frame; it also needs a free slot in the result path.
  assign eof_busy = (b_valid_r && b_eof_r) || (c_valid_r && c_eof_r);
  assign a_go     = mq_valid && !eof_busy &&
                    (!mq_head.eof || (stat.used < USED_W'(OQ_DEPTH)));
  assign mq_pop   = a_go;

  // Issue stage: seeding takes the centroid as reference, then the offsets
  // from the reference and the window test.
  always_comb begin
    for (int ln = 0; ln < NUM_LANES; ln++) begin
      a_seed[ln] = !mq_head.eof && mq_head.zone[ln] && !seeded_r[ln];
      a_rx[ln]   = a_seed[ln] ? mq_head.x : ref_x_r[ln];
      a_ry[ln]   = a_seed[ln] ? mq_head.y : ref_y_r[ln];
      a_dx[ln]   = absdiff(a_rx[ln], mq_head.x);
      a_dy[ln]   = Y_W'(absdiff(X_W'(a_ry[ln]), X_W'(mq_head.y)));
      a_win[ln]  = (a_dx[ln] <= cfg.window_x) && (a_dy[ln] <= cfg.window_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_go;
      c_valid_r <= b_valid_r;
    end
  end

  // Pipeline payload: offsets, then their squares.
  always_ff @(posedge clk) begin
    b_eof_r <= mq_head.eof;
    b_x_r   <= mq_head.x;
    b_y_r   <= mq_head.y;
    b_win_r <= a_win;
    c_eof_r <= b_eof_r;
    c_x_r   <= b_x_r;
    c_y_r   <= b_y_r;
    c_win_r <= b_win_r;
    for (int ln = 0; ln < NUM_LANES; ln++) begin
      b_dx_r[ln]  <= a_dx[ln];
      b_dy_r[ln]  <= a_dy[ln];
      c_sqx_r[ln] <= DX2_W'(b_dx_r[ln]) * DX2_W'(b_dx_r[ln]);
      c_sqy_r[ln] <= DY2_W'(b_dy_r[ln]) * DY2_W'(b_dy_r[ln]);
    end
  end

  // Compare stage: the first centroid of a frame sets the best distance,
  // later ones must be no farther to win.
  always_comb begin
    for (int ln = 0; ln < NUM_LANES; ln++) begin
      c_dist[ln]     = DIST_W'(c_sqx_r[ln]) + DIST_W'(c_sqy_r[ln]);
      c_best_eff[ln] = fresh_r ? c_dist[ln] : best_r[ln];
      c_take[ln]     = c_win_r[ln] && (c_dist[ln] <= c_best_eff[ln]);
      best_nxt[ln]   = c_take[ln] ? c_dist[ln] : c_best_eff[ln];
    end
  end

  // Lane state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int ln = 0; ln < NUM_LANES; ln++) begin
        ref_x_r[ln] <= '0;
        ref_y_r[ln] <= '0;
        cur_x_r[ln] <= '0;
        cur_y_r[ln] <= '0;
        best_r[ln]  <= '0;
      end
      seeded_r <= '0;
      fresh_r  <= 1'b1;
    end else begin
      for (int ln = 0; ln < NUM_LANES; ln++) begin
        if (a_go && a_seed[ln]) begin
          ref_x_r[ln]  <= mq_head.x;
          ref_y_r[ln]  <= mq_head.y;
          seeded_r[ln] <= 1'b1;
        end
      end
      if (c_valid_r && !c_eof_r) begin
        fresh_r <= 1'b0;
        for (int ln = 0; ln < NUM_LANES; ln++) begin
          best_r[ln] <= best_nxt[ln];
          if (c_take[ln]) begin
            cur_x_r[ln] <= c_x_r;
            cur_y_r[ln] <= c_y_r;
          end
        end
      end else if (c_valid_r && c_eof_r) begin
        fresh_r <= 1'b1;
        for (int ln = 0; ln < NUM_LANES; ln++) begin
          ref_x_r[ln] <= cur_x_r[ln];
          ref_y_r[ln] <= cur_y_r[ln];
          best_r[ln]  <= '0;
        end
      end
    end
  end

  // Frame close: twice the center minus the sum of both lane positions.
  always_comb begin
    eof_req.valid = c_valid_r && c_eof_r;
    eof_req.num   = NUM_W'({cfg.center_x, 1'b0}) - NUM_W'(cur_x_r[LANE_RIGHT]) -
                    NUM_W'(cur_x_r[LANE_LEFT]);
  end

  // A closed frame leaves both best distances cleared and the next centroid first.
  a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid_r && c_eof_r) |=> (fresh_r && best_r[LANE_RIGHT] == '0 &&
                                best_r[LANE_LEFT] == '0))
    else $error("frame close did not reset lane tracking state");

  // Only one end of frame is ever inside the tracking stages.
  a_one_eof: assert property (@(posedge clk) disable iff (!rst_n)
    !(b_valid_r && b_eof_r && c_valid_r && c_eof_r))
    else $error("two frame ends in the tracking stages");

  // Seeding happens once per lane.
  a_seed_right: assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r[LANE_RIGHT] |=> seeded_r[LANE_RIGHT])
    else $error("right lane lost its seed");

  a_seed_left: assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r[LANE_LEFT] |=> seeded_r[LANE_LEFT])
    else $error("left lane lost its seed");

endmodule

// ===== sv/lct_steer.sv =====
// Steering stages: error, gain product and saturated wheel speeds, then the result queue.
module lct_steer import lct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  eof_req_t    eof_req,
  output steer_stat_t stat,
  output out_item_t   out_data,
  output logic        empty,
  input  logic        pop
);

  localparam int SH   = COORD_FRAC_BITS + 1;
  localparam int SC_W = G_W + 2;
  localparam int BASE_Q8 = BASE_SPEED * (1 << GAIN_FRAC);
  localparam logic signed [NUM_W-1:0] ERR_HI = NUM_W'((1 << (ERR_W - 1)) - 1);
  localparam logic signed [NUM_W-1:0] ERR_LO = -ERR_HI - NUM_W'(1);
  localparam logic signed [SC_W-1:0]  SPD_HI = SC_W'((1 << (SPD_W - 1)) - 1);
  localparam logic signed [SC_W-1:0]  SPD_LO = -SPD_HI - SC_W'(1);

  logic                    s1_valid_r;
  logic [NUM_W-1:0]        s1_num_r;
  logic                    s2_valid_r;
  logic signed [ERR_W-1:0] s2_err_r;
  logic                    s3_valid_r;
  logic signed [G_W-1:0]   s3_g_r;
  // The error travels alongside the gain product into the result.
  logic signed [ERR_W-1:0] s3_err_r;

  logic [NUM_W-1:0]        bias;
  logic signed [NUM_W-1:0] biased;
  logic signed [NUM_W-1:0] quot;
  logic signed [NUM_W-1:0] err_sat;
  logic signed [G_W-1:0]   g;
  logic signed [SC_W-1:0]  t1;
  logic signed [SC_W-1:0]  t2;
  out_item_t               res;

  out_item_t        oq_mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wr_r;
  logic [OQ_AW-1:0] oq_rd_r;
  logic [OQ_CW-1:0] oq_cnt_r;
  logic             oq_pop;

  // Truncating divide by 256 with saturation to the speed range.
  function automatic logic signed [SPD_W-1:0] spd_sat(input logic signed [SC_W-1:0] t);
    logic signed [SC_W-1:0] b;
    logic signed [SC_W-1:0] q;
    b = t + (t[SC_W-1] ? SC_W'((1 << GAIN_FRAC) - 1) : SC_W'(0));
    q = b >>> GAIN_FRAC;
    if (q > SPD_HI) begin
      q = SPD_HI;
    end else if (q < SPD_LO) begin
      q = SPD_LO;
    end
    return SPD_W'(q);
  endfunction

  // Error in whole pixels, truncated toward zero, then clamped.
  always_comb begin
    bias    = s1_num_r[NUM_W-1] ? NUM_W'((1 << SH) - 1) : '0;
    biased  = $signed(s1_num_r + bias);
    quot    = biased >>> SH;
    err_sat = quot;
    if (quot > ERR_HI) begin
      err_sat = ERR_HI;
    end else if (quot < ERR_LO) begin
      err_sat = ERR_LO;
    end
  end

  // Gain times error.
  assign g = G_W'($signed({1'b0, cfg.gain_q8})) * G_W'(s2_err_r);

  // Wheel speeds.
  always_comb begin
    t1 = SC_W'(BASE_Q8) - SC_W'(s3_g_r);
    t2 = -(SC_W'(BASE_Q8) + SC_W'(s3_g_r));
    res.steer_error  = s3_err_r;
    res.first_speed  = spd_sat(t1);
    res.second_speed = spd_sat(t2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= eof_req.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_num_r <= eof_req.num;
    s2_err_r <= ERR_W'(err_sat);
    s3_err_r <= s2_err_r;
    s3_g_r   <= g;
  end

  // Result queue.
  assign oq_pop   = pop && !empty;
  assign empty    = (oq_cnt_r == '0);
  assign out_data = oq_mem_r[oq_rd_r];
  assign stat.used = USED_W'(oq_cnt_r) + USED_W'(s1_valid_r) +
                     USED_W'(s2_valid_r) + USED_W'(s3_valid_r);

  always_ff @(posedge clk) begin
    if (s3_valid_r) begin
      oq_mem_r[oq_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (s3_valid_r) begin
        oq_wr_r <= (oq_wr_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= (oq_rd_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_rd_r + 1'b1;
      end
      if (s3_valid_r && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (oq_pop && !s3_valid_r) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

  // A result reaching the queue always finds a free slot.
  a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (oq_cnt_r < OQ_CW'(OQ_DEPTH)))
    else $error("result written into a full queue");

  // Reserved slots never exceed the queue depth.
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    stat.used <= USED_W'(OQ_DEPTH))
    else $error("result path over-committed");

endmodule

// ===== sv/lane_centroid_tracker_steer.sv =====
// Top level of the lane centroid tracker with proportional steering.
// Throughput: one beat per cycle; an end-of-frame beat holds the next beat back
// while it closes the frame, and waits until the result path has room.
// A result passes from its end-of-frame beat through the beat queue, two tracking
// registers, three steering registers and the result queue.
// Reset is synchronous, active low: queues empty, lanes cleared, registers at defaults.
module lane_centroid_tracker_steer import lct_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_data,
  input  logic              push,
  output logic              full,
  output out_item_t         out_data,
  output logic              empty,
  input  logic              pop,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t        cfg;
  mq_item_t    mq_head;
  logic        mq_valid;
  logic        mq_pop;
  steer_stat_t stat;
  eof_req_t    eof_req;

  lct_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lct_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_data  (in_data),
    .push     (push),
    .full     (full),
    .mq_head  (mq_head),
    .mq_valid (mq_valid),
    .mq_pop   (mq_pop)
  );

  lct_track u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .mq_head  (mq_head),
    .mq_valid (mq_valid),
    .mq_pop   (mq_pop),
    .stat     (stat),
    .eof_req  (eof_req)
  );

  lct_steer u_steer (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .eof_req  (eof_req),
    .stat     (stat),
    .out_data (out_data),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

// ===== bench/lane_centroid_tracker_steer_test.sv =====
// Self-checking testbench for the lane centroid tracker with proportional steering.
`timescale 1ns / 100ps

module lane_centroid_tracker_steer_test;
  import lct_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;

  // Lane state kept by the predictor.
  typedef struct {
    logic [X_W-1:0]    ref_x;
    logic [Y_W-1:0]    ref_y;
    logic [X_W-1:0]    cur_x;
    logic [Y_W-1:0]    cur_y;
    logic [DIST_W-1:0] best;
    bit                seeded;
  } lane_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  in_item_t          in_data = '0;
  logic              push = 1'b0;
  logic              full;
  out_item_t         out_data;
  logic              empty;
  logic              pop = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  cfg_t      cfg;
  lane_t     lanes [NUM_LANES];
  bit        frame_fresh;
  out_item_t expected_steer [$];
  out_item_t steer_head;
  int        fail_count = 0;
  int        cycle_count = 0;
  int        pop_gap = 0;
  bit        in_calm = 1'b0;
  bit        out_calm = 1'b0;

  lane_centroid_tracker_steer u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .push    (push),
    .full    (full),
    .out_data(out_data),
    .empty   (empty),
    .pop     (pop),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // Cycle counter with a hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Idle cycles before the next beat on either side.
  function automatic int gap_draw(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 8));
  endfunction

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [DIST_W-1:0] span_sq(input int ax, input int ay,
                                                input int bx, input int by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return DIST_W'(dx * dx + dy * dy);
  endfunction

  function automatic logic [CFG_DW-1:0] reg_field(input cfg_t c, input cfg_reg_t r);
    case (r)
      REG_CENTER_X:         return CFG_DW'(c.center_x);
      REG_CENTER_Y:         return CFG_DW'(c.center_y);
      REG_RIGHT_SEED_MIN_X: return CFG_DW'(c.right_seed_min_x);
      REG_LEFT_SEED_MAX_X:  return CFG_DW'(c.left_seed_max_x);
      REG_SEED_MIN_Y:       return CFG_DW'(c.seed_min_y);
      REG_WINDOW_X:         return CFG_DW'(c.window_x);
      REG_WINDOW_Y:         return CFG_DW'(c.window_y);
      REG_GAIN_Q8:          return CFG_DW'(c.gain_q8);
      default:              return '0;
    endcase
  endfunction

  function automatic void reg_store(input cfg_reg_t r, input logic [CFG_DW-1:0] v);
    case (r)
      REG_CENTER_X:         cfg.center_x = v[X_W-1:0];
      REG_CENTER_Y:         cfg.center_y = v[Y_W-1:0];
      REG_RIGHT_SEED_MIN_X: cfg.right_seed_min_x = v[X_W-1:0];
      REG_LEFT_SEED_MAX_X:  cfg.left_seed_max_x = v[X_W-1:0];
      REG_SEED_MIN_Y:       cfg.seed_min_y = v[Y_W-1:0];
      REG_WINDOW_X:         cfg.window_x = v[X_W-1:0];
      REG_WINDOW_Y:         cfg.window_y = v[Y_W-1:0];
      REG_GAIN_Q8:          cfg.gain_q8 = v[GAIN_W-1:0];
      default:              ;
    endcase
  endfunction

  // Advances the lane tracker by one accepted beat and queues the steering result
  // that an end-of-frame beat produces.
  function automatic void track_and_steer(input in_item_t item);
    int                x;
    int                y;
    int                rx;
    int                ry;
    int                adx;
    int                ady;
    bit                in_zone;
    logic [DIST_W-1:0] d [NUM_LANES];
    longint            cx;
    longint            sum_x;
    longint            num;
    longint            err;
    longint            g;
    longint            base;
    out_item_t         res;
    x = int'(item.blob_x);
    y = int'(item.blob_y);
    if (item.mode == 1'b0) begin
      // Seed a lane once, then measure from its reference.
      for (int l = 0; l < NUM_LANES; l++) begin
        if (l == LANE_RIGHT) in_zone = x > int'(cfg.right_seed_min_x);
        else in_zone = x < int'(cfg.left_seed_max_x);
        if (!lanes[l].seeded && in_zone && y > int'(cfg.seed_min_y)) begin
          lanes[l].ref_x = item.blob_x;
          lanes[l].ref_y = item.blob_y;
          lanes[l].cur_x = item.blob_x;
          lanes[l].cur_y = item.blob_y;
          lanes[l].seeded = 1'b1;
          lanes[l].best = span_sq(x, y, int'(cfg.center_x), int'(cfg.center_y));
        end
        d[l] = span_sq(int'(lanes[l].ref_x), int'(lanes[l].ref_y), x, y);
      end
      if (frame_fresh) begin
        for (int l = 0; l < NUM_LANES; l++) lanes[l].best = d[l];
        frame_fresh = 1'b0;
      end
      // Keep the nearest centroid inside each lane's window; ties go to the later one.
      for (int l = 0; l < NUM_LANES; l++) begin
        rx = int'(lanes[l].ref_x);
        ry = int'(lanes[l].ref_y);
        adx = (rx > x) ? rx - x : x - rx;
        ady = (ry > y) ? ry - y : y - ry;
        if (adx <= int'(cfg.window_x) && ady <= int'(cfg.window_y) &&
            d[l] <= lanes[l].best) begin
          lanes[l].best = d[l];
          lanes[l].cur_x = item.blob_x;
          lanes[l].cur_y = item.blob_y;
        end
      end
      return;
    end
    // End of frame: steering error in whole pixels, then the two wheel speeds.
    cx = longint'(cfg.center_x);
    sum_x = longint'(lanes[LANE_RIGHT].cur_x);
    sum_x += longint'(lanes[LANE_LEFT].cur_x);
    num = 2 * cx - sum_x;
    err = sat(num / (longint'(2) << COORD_FRAC_BITS), -4096, 4095);
    g = longint'(cfg.gain_q8);
    g = g * err;
    base = longint'(BASE_SPEED) << GAIN_FRAC;
    res.steer_error = err[ERR_W-1:0];
    res.first_speed = SPD_W'(sat((base - g) / (longint'(1) << GAIN_FRAC), -32768, 32767));
    res.second_speed = SPD_W'(sat(-(base + g) / (longint'(1) << GAIN_FRAC),
                                  -32768, 32767));
    expected_steer = {expected_steer, res};
    for (int l = 0; l < NUM_LANES; l++) begin
      lanes[l].ref_x = lanes[l].cur_x;
      lanes[l].ref_y = lanes[l].cur_y;
      lanes[l].best = '0;
    end
    frame_fresh = 1'b1;
  endfunction

  // Register write: setup cycle, then access cycle.
  task automatic cfg_write(input cfg_reg_t r, input logic [CFG_DW-1:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    reg_store(r, v);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_read_check(input cfg_reg_t r);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {r, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== reg_field(cfg, r)) begin
      $display("%0t register %s readback: expected %0h actual %0h", $time, r.name(),
               reg_field(cfg, r), prdata);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_apply(input cfg_t c);
    for (int i = 0; i <= int'(REG_GAIN_Q8); i++) begin
      cfg_write(cfg_reg_t'(i), reg_field(c, cfg_reg_t'(i)));
    end
  endtask

  // Sends one beat; push stays high afterwards so that back-to-back beats need no gap.
  task automatic send_beat(input in_item_t item);
    int gap;
    gap = gap_draw(in_calm);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (full);
    track_and_steer(item);
  endtask

  task automatic send_centroid(input int x, input int y);
    in_item_t item;
    item.mode = 1'b0;
    item.blob_x = x[X_W-1:0];
    item.blob_y = y[Y_W-1:0];
    send_beat(item);
  endtask

  task automatic send_eof();
    in_item_t item;
    item.mode = 1'b1;
    item.blob_x = X_W'($urandom);
    item.blob_y = Y_W'($urandom);
    send_beat(item);
  endtask

  // Lets every queued result arrive and the pipeline empty out.
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (expected_steer.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Centroid mostly near a lane, sometimes on a lane's current pick, sometimes anywhere.
  function automatic in_item_t centroid_draw();
    in_item_t item;
    int       pick;
    int       l;
    int       spread_x;
    int       spread_y;
    int       x;
    int       y;
    pick = int'($urandom_range(0, 99));
    l = int'($urandom_range(0, NUM_LANES - 1));
    item.mode = 1'b0;
    if (pick < 65) begin
      spread_x = ((cfg.window_x > 3000) ? 3000 : int'(cfg.window_x)) + 8;
      spread_y = ((cfg.window_y > 3000) ? 3000 : int'(cfg.window_y)) + 8;
      x = int'(lanes[l].ref_x);
      y = int'(lanes[l].ref_y);
      x += int'($urandom_range(0, 2 * spread_x)) - spread_x;
      y += int'($urandom_range(0, 2 * spread_y)) - spread_y;
      item.blob_x = X_W'(sat(longint'(x), 0, 65535));
      item.blob_y = Y_W'(sat(longint'(y), 0, 16383));
    end else if (pick < 80) begin
      item.blob_x = lanes[l].cur_x;
      item.blob_y = lanes[l].cur_y;
    end else begin
      item.blob_x = X_W'($urandom);
      item.blob_y = Y_W'($urandom);
    end
    return item;
  endfunction

  task automatic test_register_access();
    for (int i = 0; i <= int'(REG_GAIN_Q8); i++) begin
      cfg_write(cfg_reg_t'(i), $urandom);
      cfg_read_check(cfg_reg_t'(i));
      cfg_write(cfg_reg_t'(i), '1);
      cfg_read_check(cfg_reg_t'(i));
      cfg_write(cfg_reg_t'(i), '0);
      cfg_read_check(cfg_reg_t'(i));
    end
    cfg_apply(CFG_RESET);
  endtask

  // Empty frame straight after reset, then tracking from the zero references.
  task automatic test_unseeded_lanes();
    send_eof();
    send_centroid(0, 0);
    send_centroid(100, 300);
    send_eof();
  endtask

  task automatic test_lane_seeding();
    send_centroid(7040, 500);
    send_centroid(8000, 321);
    send_centroid(1000, 600);
    send_centroid(3200, 700);
    send_centroid(65535, 16383);
    send_eof();
  endtask

  // Nearest pick, equal distances, and both edges of the window.
  task automatic test_nearest_choice();
    send_centroid(8300, 321);
    send_centroid(7700, 321);
    send_centroid(8010, 330);
    send_centroid(8000 + 1121, 321);
    send_centroid(1050, 600 + 960);
    send_centroid(1000, 600 + 961);
    send_eof();
  endtask

  // Largest positive and negative steering error, largest and zero gain.
  task automatic test_steer_limits();
    settle();
    cfg_write(REG_WINDOW_X, 32'hFFFF);
    cfg_write(REG_WINDOW_Y, 32'h3FFF);
    cfg_write(REG_GAIN_Q8, 32'h3FF);
    cfg_write(REG_CENTER_X, 32'hFFFF);
    send_centroid(0, 0);
    send_eof();
    send_centroid(65535, 16383);
    send_eof();
    settle();
    cfg_write(REG_CENTER_X, 32'h0);
    send_eof();
    settle();
    cfg_write(REG_GAIN_Q8, 32'h0);
    send_eof();
    settle();
    cfg_apply(CFG_RESET);
  endtask

  // Frames of random length under a series of settings, extremes included.
  task automatic test_random_configs();
    cfg_t c;
    int   sent;
    int   frame_len;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: c = CFG_RESET;
        1: c = '1;
        2: c = '0;
        default: begin
          c.center_x = X_W'($urandom);
          c.center_y = Y_W'($urandom);
          c.right_seed_min_x = X_W'($urandom);
          c.left_seed_max_x = X_W'($urandom);
          c.seed_min_y = Y_W'($urandom);
          c.window_x = X_W'($urandom_range(0, 4000));
          c.window_y = Y_W'($urandom_range(0, 4000));
          c.gain_q8 = GAIN_W'($urandom);
        end
      endcase
      settle();
      cfg_apply(c);
      sent = 0;
      while (sent < 170) begin
        in_calm = ($urandom_range(0, 5) == 0);
        out_calm = ($urandom_range(0, 5) == 0);
        frame_len = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 12));
        repeat (frame_len) begin
          send_beat(centroid_draw());
          sent++;
        end
        send_eof();
        sent++;
      end
    end
    in_calm = 1'b0;
    out_calm = 1'b0;
  endtask

  // Result side: random stalls between beats.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (pop_gap > 0) begin
        pop <= 1'b0;
        pop_gap--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) pop_gap = gap_draw(out_calm);
    end
  end

  task automatic flag_field(input string name, input logic signed [31:0] expv,
                            input logic signed [31:0] actv);
    if (expv !== actv) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, expv, actv);
      fail_count++;
    end
  endtask

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_steer.size() == 0) begin
        $display("%0t unexpected result beat: expected none actual %0d %0d %0d", $time,
                 $signed(out_data.steer_error), $signed(out_data.first_speed),
                 $signed(out_data.second_speed));
        fail_count++;
      end else begin
        steer_head = expected_steer.pop_front();
        flag_field("steer_error", 32'(steer_head.steer_error), 32'(out_data.steer_error));
        flag_field("first_speed", 32'(steer_head.first_speed), 32'(out_data.first_speed));
        flag_field("second_speed", 32'(steer_head.second_speed),
                   32'(out_data.second_speed));
      end
    end
  end

  initial begin
    cfg = CFG_RESET;
    for (int l = 0; l < NUM_LANES; l++) lanes[l] = '{default: '0};
    frame_fresh = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_register_access();
    test_unseeded_lanes();
    test_lane_seeding();
    test_nearest_choice();
    test_steer_limits();
    test_random_configs();
    settle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== lane_centroid_tracker_steer.f =====
sv/lct_pkg.sv
sv/lct_cfg.sv
sv/lct_front.sv
sv/lct_track.sv
sv/lct_steer.sv
sv/lane_centroid_tracker_steer.sv
bench/lane_centroid_tracker_steer_test.sv
